/* rtl/hsvtmc_pkg.sv */
// hsvtmc_pkg: shared types, register indexes and the range test for the
// HSV threshold and centroid block. No dependencies.
package hsvtmc_pkg;

	localparam int CFG_W    = 8;
	localparam int REG_IDX_W = 3;
	localparam int CENT_W   = 12;
	localparam int MCNT_W   = 23;

	localparam logic [REG_IDX_W-1:0] REG_HUE_LOW  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_HUE_HIGH = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SAT_LOW  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SAT_HIGH = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_VAL_LOW  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_VAL_HIGH = 3'd5;

	localparam logic [CENT_W-1:0] CENTROID_NONE = {CENT_W{1'b1}};

	typedef struct packed {
		logic [CFG_W-1:0] hue_low;
		logic [CFG_W-1:0] hue_high;
		logic [CFG_W-1:0] sat_low;
		logic [CFG_W-1:0] sat_high;
		logic [CFG_W-1:0] val_low;
		logic [CFG_W-1:0] val_high;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		hue_low:  8'd100,
		hue_high: 8'd110,
		sat_low:  8'd130,
		sat_high: 8'd255,
		val_low:  8'd100,
		val_high: 8'd140
	};

	// equal limits pass all; low above high is a wrapped range
	function automatic logic in_range(input logic [CFG_W-1:0] v,
		input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
		logic r;
		if (lo == hi) begin
			r = 1'b1;
		end else if (lo > hi) begin
			r = (v >= lo) || (v <= hi);
		end else begin
			r = (v >= lo) && (v <= hi);
		end
		return r;
	endfunction

endpackage

/* rtl/hsv_threshold_mask_centroid.sv */
// hsv_threshold_mask_centroid: top level; configuration registers, front end,
// queue and back end. Depends on hsvtmc_pkg, hsvtmc_front, hsvtmc_queue, hsvtmc_back.
//
//  channel   handshake         beat
//  pixel     push / full       hue, saturation, brightness, end_of_line, end_of_frame
//  result    pop / empty       mask_bit, frame_done, centroid_x, centroid_y, match_count
//  config    wr_en             wr_index, wr_data
//
// Ordinary pixels: one per cycle while full is low.
// A frame end with matches holds the back end in the division loop while the
// front keeps taking pixels until the queue fills, then full is raised.
// Reset clears coordinates, sums, queue and result valid; no clearing pass.
module hsv_threshold_mask_centroid #(
	parameter int MAX_WIDTH   = 2048,
	parameter int MAX_HEIGHT  = 2048,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic [7:0]                           hue,
	input  logic [7:0]                           saturation,
	input  logic [7:0]                           brightness,
	input  logic                                 end_of_line,
	input  logic                                 end_of_frame,
	output logic                                 empty,
	input  logic                                 pop,
	output logic                                 mask_bit,
	output logic                                 frame_done,
	output logic signed [hsvtmc_pkg::CENT_W-1:0] centroid_x,
	output logic signed [hsvtmc_pkg::CENT_W-1:0] centroid_y,
	output logic [hsvtmc_pkg::MCNT_W-1:0]        match_count,
	input  logic                                 wr_en,
	input  logic [hsvtmc_pkg::REG_IDX_W-1:0]     wr_index,
	input  logic [hsvtmc_pkg::CFG_W-1:0]         wr_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int QW = (CW > RW) ? CW : RW;
	localparam int NW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int SW = NW + QW;
	localparam int EW = 2 + NW + 2 * SW;

	hsvtmc_pkg::cfg_t cfg_q;
	logic             accept;
	logic             f_hit;
	logic [NW-1:0]    f_cnt;
	logic [SW-1:0]    f_sx;
	logic [SW-1:0]    f_sy;
	logic [EW-1:0]    q_wdata;
	logic [EW-1:0]    q_rdata;
	logic             q_empty;
	logic             q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= hsvtmc_pkg::CFG_RESET;
		end else if (wr_en) begin
			case (wr_index)
				hsvtmc_pkg::REG_HUE_LOW:  cfg_q.hue_low  <= wr_data;
				hsvtmc_pkg::REG_HUE_HIGH: cfg_q.hue_high <= wr_data;
				hsvtmc_pkg::REG_SAT_LOW:  cfg_q.sat_low  <= wr_data;
				hsvtmc_pkg::REG_SAT_HIGH: cfg_q.sat_high <= wr_data;
				hsvtmc_pkg::REG_VAL_LOW:  cfg_q.val_low  <= wr_data;
				hsvtmc_pkg::REG_VAL_HIGH: cfg_q.val_high <= wr_data;
				default: begin
				end
			endcase
		end
	end

	assign accept  = push && !full;
	assign q_wdata = {f_hit, end_of_frame, f_cnt, f_sx, f_sy};

	hsvtmc_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.accept       (accept),
		.hue          (hue),
		.saturation   (saturation),
		.brightness   (brightness),
		.end_of_line  (end_of_line),
		.end_of_frame (end_of_frame),
		.hit          (f_hit),
		.cnt_out      (f_cnt),
		.sum_x_out    (f_sx),
		.sum_y_out    (f_sy)
	);

	hsvtmc_queue #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (q_wdata),
		.full   (full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	hsvtmc_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.e_hit       (q_rdata[EW-1]),
		.e_eof       (q_rdata[EW-2]),
		.e_cnt       (q_rdata[EW-3 -: NW]),
		.e_sx        (q_rdata[2*SW-1 -: SW]),
		.e_sy        (q_rdata[SW-1:0]),
		.pop         (pop),
		.empty       (empty),
		.mask_bit    (mask_bit),
		.frame_done  (frame_done),
		.centroid_x  (centroid_x),
		.centroid_y  (centroid_y),
		.match_count (match_count)
	);

endmodule

/* rtl/hsvtmc_queue.sv */
// hsvtmc_queue: small register queue between front and back end.
// Depends on nothing.
module hsvtmc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [FW-1:0]    fill_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (fill_q == FW'(DEPTH));
	assign empty   = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + FW'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - FW'(1);
			end
		end
	end

endmodule

/* rtl/hsvtmc_front.sv */
// hsvtmc_front: range tests, raster coordinates and per-frame sums.
// Depends on hsvtmc_pkg.
module hsvtmc_front #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int RW = $clog2(MAX_HEIGHT),
	localparam int QW = (CW > RW) ? CW : RW,
	localparam int NW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
	localparam int SW = NW + QW
) (
	input  logic               clk,
	input  logic               arst_n,
	input  hsvtmc_pkg::cfg_t   cfg,
	input  logic               accept,
	input  logic [7:0]         hue,
	input  logic [7:0]         saturation,
	input  logic [7:0]         brightness,
	input  logic               end_of_line,
	input  logic               end_of_frame,
	output logic               hit,
	output logic [NW-1:0]      cnt_out,
	output logic [SW-1:0]      sum_x_out,
	output logic [SW-1:0]      sum_y_out
);

	localparam logic [NW-1:0] CNT_MAX = NW'(MAX_WIDTH * MAX_HEIGHT);
	localparam logic [CW-1:0] COL_MAX = CW'(MAX_WIDTH - 1);
	localparam logic [RW-1:0] ROW_MAX = RW'(MAX_HEIGHT - 1);

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [NW-1:0] cnt_q;
	logic [SW-1:0] sx_q;
	logic [SW-1:0] sy_q;
	logic          add;

	assign hit = hsvtmc_pkg::in_range(hue, cfg.hue_low, cfg.hue_high)
		&& hsvtmc_pkg::in_range(saturation, cfg.sat_low, cfg.sat_high)
		&& hsvtmc_pkg::in_range(brightness, cfg.val_low, cfg.val_high);
	assign add = hit && (cnt_q < CNT_MAX);

	assign cnt_out   = add ? cnt_q + NW'(1) : cnt_q;
	assign sum_x_out = add ? sx_q + SW'(col_q) : sx_q;
	assign sum_y_out = add ? sy_q + SW'(row_q) : sy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			cnt_q <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
		end else if (accept) begin
			if (end_of_frame) begin
				col_q <= '0;
				row_q <= '0;
				cnt_q <= '0;
				sx_q  <= '0;
				sy_q  <= '0;
			end else begin
				cnt_q <= cnt_out;
				sx_q  <= sum_x_out;
				sy_q  <= sum_y_out;
				if (end_of_line) begin
					col_q <= '0;
					if (row_q < ROW_MAX) begin
						row_q <= row_q + RW'(1);
					end
				end else if (col_q < COL_MAX) begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX) else $error("match count beyond limit");
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COL_MAX) else $error("column beyond limit");
	a_eof_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_frame |=> cnt_q == '0 && col_q == '0 && row_q == '0)
		else $error("frame end did not clear sums");

endmodule

/* rtl/hsvtmc_back.sv */
// hsvtmc_back: takes classified beats from the queue, runs the centroid
// division on frame ends, holds the result register. Depends on hsvtmc_pkg.
module hsvtmc_back #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int RW = $clog2(MAX_HEIGHT),
	localparam int QW = (CW > RW) ? CW : RW,
	localparam int NW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
	localparam int SW = NW + QW
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_empty,
	output logic                                q_pop,
	input  logic                                e_hit,
	input  logic                                e_eof,
	input  logic [NW-1:0]                       e_cnt,
	input  logic [SW-1:0]                       e_sx,
	input  logic [SW-1:0]                       e_sy,
	input  logic                                pop,
	output logic                                empty,
	output logic                                mask_bit,
	output logic                                frame_done,
	output logic signed [hsvtmc_pkg::CENT_W-1:0] centroid_x,
	output logic signed [hsvtmc_pkg::CENT_W-1:0] centroid_y,
	output logic [hsvtmc_pkg::MCNT_W-1:0]        match_count
);

	localparam int CNW = hsvtmc_pkg::CENT_W;
	localparam int MCW = hsvtmc_pkg::MCNT_W;
	localparam int SCW = $clog2(QW + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]     state_q;
	logic [SCW-1:0] step_q;
	logic           hit_q;
	logic [NW-1:0]  div_q;
	logic [NW-1:0]  rem_x_q;
	logic [NW-1:0]  rem_y_q;
	logic [QW-1:0]  lo_x_q;
	logic [QW-1:0]  lo_y_q;

	logic           out_valid_q;
	logic           mask_q;
	logic           done_q;
	logic [CNW-1:0] cx_q;
	logic [CNW-1:0] cy_q;
	logic [MCW-1:0] mcnt_q;

	logic           out_free;
	logic           needs_div;
	logic           load_direct;
	logic           load_div;
	logic [NW:0]    cat_x;
	logic [NW:0]    cat_y;
	logic           ge_x;
	logic           ge_y;
	logic [NW:0]    sub_x;
	logic [NW:0]    sub_y;
	logic [QW:0]    lo_cat_x;
	logic [QW:0]    lo_cat_y;
	logic [QW+CNW-1:0] qx_ext;
	logic [QW+CNW-1:0] qy_ext;
	logic [NW+MCW-1:0] ecnt_ext;
	logic [NW+MCW-1:0] dcnt_ext;

	assign out_free    = !out_valid_q || pop;
	assign needs_div   = e_eof && (e_cnt != '0);
	assign load_direct = (state_q == ST_IDLE) && !q_empty && !needs_div && out_free;
	assign load_div    = (state_q == ST_DONE) && out_free;
	assign q_pop       = (state_q == ST_IDLE) && !q_empty && (needs_div || out_free);

	// one restoring step per cycle on both sums
	assign cat_x    = {rem_x_q, lo_x_q[QW-1]};
	assign cat_y    = {rem_y_q, lo_y_q[QW-1]};
	assign ge_x     = cat_x >= {1'b0, div_q};
	assign ge_y     = cat_y >= {1'b0, div_q};
	assign sub_x    = cat_x - {1'b0, div_q};
	assign sub_y    = cat_y - {1'b0, div_q};
	assign lo_cat_x = {lo_x_q, ge_x};
	assign lo_cat_y = {lo_y_q, ge_y};

	assign qx_ext   = {{CNW{1'b0}}, lo_x_q};
	assign qy_ext   = {{CNW{1'b0}}, lo_y_q};
	assign ecnt_ext = {{MCW{1'b0}}, e_cnt};
	assign dcnt_ext = {{MCW{1'b0}}, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_pop && needs_div) begin
						state_q <= ST_DIV;
						step_q  <= SCW'(QW - 1);
					end
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q - SCW'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && needs_div) begin
			hit_q   <= e_hit;
			div_q   <= e_cnt;
			rem_x_q <= e_sx[SW-1:QW];
			rem_y_q <= e_sy[SW-1:QW];
			lo_x_q  <= e_sx[QW-1:0];
			lo_y_q  <= e_sy[QW-1:0];
		end else if (state_q == ST_DIV) begin
			rem_x_q <= ge_x ? sub_x[NW-1:0] : cat_x[NW-1:0];
			rem_y_q <= ge_y ? sub_y[NW-1:0] : cat_y[NW-1:0];
			lo_x_q  <= lo_cat_x[QW-1:0];
			lo_y_q  <= lo_cat_y[QW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_direct || load_div) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_direct) begin
			mask_q <= e_hit;
			done_q <= e_eof;
			cx_q   <= e_eof ? hsvtmc_pkg::CENTROID_NONE : '0;
			cy_q   <= e_eof ? hsvtmc_pkg::CENTROID_NONE : '0;
			mcnt_q <= e_eof ? ecnt_ext[MCW-1:0] : '0;
		end else if (load_div) begin
			mask_q <= hit_q;
			done_q <= 1'b1;
			cx_q   <= qx_ext[CNW-1:0];
			cy_q   <= qy_ext[CNW-1:0];
			mcnt_q <= dcnt_ext[MCW-1:0];
		end
	end

	assign empty       = !out_valid_q;
	assign mask_bit    = mask_q;
	assign frame_done  = done_q;
	assign centroid_x  = signed'(cx_q);
	assign centroid_y  = signed'(cy_q);
	assign match_count = mcnt_q;

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> div_q != '0) else $error("division by zero count");
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && step_q == '0 |=> state_q == ST_DONE)
		else $error("division did not finish");
	a_pop_lands: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q == ST_DIV || out_valid_q)
		else $error("queue beat lost");
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && !out_free |=> state_q == ST_DONE)
		else $error("centroid dropped while stalled");

endmodule

/* verif/testbench.sv */
// testbench: self-checking bench for hsv_threshold_mask_centroid. Drives pixel beats,
// predicts mask bit and per-frame centroid for each one and checks every result beat.
// Depends on hsvtmc_pkg and the block's RTL.
`timescale 1ns / 100ps

module testbench;

	localparam int CFG_W     = hsvtmc_pkg::CFG_W;
	localparam int REG_IDX_W = hsvtmc_pkg::REG_IDX_W;
	localparam int CENT_W    = hsvtmc_pkg::CENT_W;
	localparam int MCNT_W    = hsvtmc_pkg::MCNT_W;

	localparam int MAX_W        = 2048;
	localparam int MAX_H        = 2048;
	localparam int AREA         = MAX_W * MAX_H;
	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 70;
	localparam int DRAIN_CYCLES = 20;

	// indexes past the last register; writes there must be ignored
	localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [7:0] hue;
		logic [7:0] saturation;
		logic [7:0] brightness;
		logic       end_of_line;
		logic       end_of_frame;
	} pixel_t;

	typedef struct packed {
		logic                     mask_bit;
		logic                     frame_done;
		logic signed [CENT_W-1:0] centroid_x;
		logic signed [CENT_W-1:0] centroid_y;
		logic [MCNT_W-1:0]        match_count;
	} result_t;

	typedef struct packed {
		pixel_t  px;
		logic    typed;
		result_t want;
	} row_t;

	localparam result_t R_NONE  = '0;
	localparam result_t R_MISS  = '{1'b0, 1'b0, 12'sd0, 12'sd0, 23'd0};
	localparam result_t R_HIT   = '{1'b1, 1'b0, 12'sd0, 12'sd0, 23'd0};
	localparam result_t R_EMPTY = '{1'b0, 1'b1, -12'sd1, -12'sd1, 23'd0};
	localparam result_t R_LONE  = '{1'b1, 1'b1, 12'sd0, 12'sd0, 23'd1};

	// run at reset limits: hue 100..110, sat 130..255, val 100..140
	localparam row_t DIRECTED [15] = '{
		'{'{8'd0,   8'd0,   8'd0,   1'b0, 1'b0}, 1'b1, R_MISS},
		'{'{8'd255, 8'd255, 8'd255, 1'b0, 1'b0}, 1'b1, R_MISS},
		'{'{8'd100, 8'd130, 8'd100, 1'b0, 1'b0}, 1'b1, R_HIT},
		'{'{8'd110, 8'd255, 8'd140, 1'b1, 1'b0}, 1'b1, R_HIT},
		'{'{8'd99,  8'd200, 8'd120, 1'b0, 1'b0}, 1'b1, R_MISS},
		'{'{8'd111, 8'd200, 8'd120, 1'b0, 1'b0}, 1'b1, R_MISS},
		'{'{8'd105, 8'd129, 8'd120, 1'b0, 1'b0}, 1'b1, R_MISS},
		'{'{8'd105, 8'd200, 8'd99,  1'b0, 1'b0}, 1'b1, R_MISS},
		'{'{8'd105, 8'd200, 8'd141, 1'b1, 1'b0}, 1'b1, R_MISS},
		'{'{8'd105, 8'd200, 8'd120, 1'b0, 1'b1}, 1'b0, R_NONE},
		'{'{8'd0,   8'd0,   8'd0,   1'b0, 1'b1}, 1'b1, R_EMPTY},
		'{'{8'd105, 8'd200, 8'd120, 1'b1, 1'b1}, 1'b1, R_LONE},
		'{'{8'd105, 8'd200, 8'd120, 1'b0, 1'b1}, 1'b1, R_LONE},
		'{'{8'd255, 8'd0,   8'd255, 1'b1, 1'b0}, 1'b1, R_MISS},
		'{'{8'd0,   8'd255, 8'd0,   1'b0, 1'b1}, 1'b1, R_EMPTY}
	};

	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     push         = 1'b0;
	logic                     full;
	logic [7:0]               hue          = '0;
	logic [7:0]               saturation   = '0;
	logic [7:0]               brightness   = '0;
	logic                     end_of_line  = 1'b0;
	logic                     end_of_frame = 1'b0;
	logic                     empty;
	logic                     pop          = 1'b0;
	logic                     mask_bit;
	logic                     frame_done;
	logic signed [CENT_W-1:0] centroid_x;
	logic signed [CENT_W-1:0] centroid_y;
	logic [MCNT_W-1:0]        match_count;
	logic                     wr_en        = 1'b0;
	logic [REG_IDX_W-1:0]     wr_index     = '0;
	logic [CFG_W-1:0]         wr_data      = '0;

	// predictor copy of limits and raster state
	logic [7:0]        limits [6] = '{8'd100, 8'd110, 8'd130, 8'd255, 8'd100, 8'd140};
	logic [10:0]       col_pos    = '0;
	logic [10:0]       row_pos    = '0;
	logic [32:0]       col_sum    = '0;
	logic [32:0]       row_sum    = '0;
	logic [MCNT_W-1:0] hits       = '0;

	result_t pending_results [$];
	logic    cur_typed = 1'b0;
	result_t cur_want  = '0;
	int      send_idle  = 0;
	int      recv_stall = 0;
	int      errors        = 0;
	int      pixels_sent   = 0;
	int      results_seen  = 0;
	int      frames_seen   = 0;
	int      settings_used = 0;

	hsv_threshold_mask_centroid #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.hue         (hue),
		.saturation  (saturation),
		.brightness  (brightness),
		.end_of_line (end_of_line),
		.end_of_frame(end_of_frame),
		.empty       (empty),
		.pop         (pop),
		.mask_bit    (mask_bit),
		.frame_done  (frame_done),
		.centroid_x  (centroid_x),
		.centroid_y  (centroid_y),
		.match_count (match_count),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data)
	);

	always #1 clk = ~clk;

	function automatic logic passes(logic [7:0] v, logic [7:0] lo, logic [7:0] hi);
		if (lo == hi) begin
			return 1'b1;
		end else if (lo > hi) begin
			return (v >= lo) || (v <= hi);
		end
		return (v >= lo) && (v <= hi);
	endfunction

	// advances the raster state by one pixel and gives its result beat
	function automatic result_t score_pixel(pixel_t px);
		result_t r;
		logic    hit;
		hit = passes(px.hue, limits[hsvtmc_pkg::REG_HUE_LOW], limits[hsvtmc_pkg::REG_HUE_HIGH])
			&& passes(px.saturation, limits[hsvtmc_pkg::REG_SAT_LOW],
				limits[hsvtmc_pkg::REG_SAT_HIGH])
			&& passes(px.brightness, limits[hsvtmc_pkg::REG_VAL_LOW],
				limits[hsvtmc_pkg::REG_VAL_HIGH]);
		if (hit && hits < AREA) begin
			col_sum = col_sum + 33'(col_pos);
			row_sum = row_sum + 33'(row_pos);
			hits = hits + 1'b1;
		end
		r = '0;
		r.mask_bit = hit;
		r.frame_done = px.end_of_frame;
		if (px.end_of_frame) begin
			if (hits != 0) begin
				r.centroid_x = CENT_W'(col_sum / hits);
				r.centroid_y = CENT_W'(row_sum / hits);
			end else begin
				r.centroid_x = hsvtmc_pkg::CENTROID_NONE;
				r.centroid_y = hsvtmc_pkg::CENTROID_NONE;
			end
			r.match_count = hits;
			col_sum = '0;
			row_sum = '0;
			hits = '0;
			col_pos = '0;
			row_pos = '0;
		end else if (px.end_of_line) begin
			col_pos = '0;
			if (row_pos < MAX_H - 1) row_pos = row_pos + 1'b1;
		end else if (col_pos < MAX_W - 1) begin
			col_pos = col_pos + 1'b1;
		end
		return r;
	endfunction

	task automatic check_field(string name, logic signed [23:0] exp, logic signed [23:0] act);
		if (act !== exp) begin
			$error("%s: expected %0d, got %0d", name, exp, act);
			errors++;
		end
	endtask

	always @(posedge clk) begin : watch
		result_t want;
		if (arst_n) begin
			if (wr_en && wr_index <= hsvtmc_pkg::REG_VAL_HIGH) limits[wr_index] = wr_data;
			if (push && !full) begin
				want = score_pixel('{hue, saturation, brightness, end_of_line, end_of_frame});
				if (cur_typed) want = cur_want;
				pending_results.push_back(want);
			end
			if (pop && !empty) begin
				results_seen++;
				if (frame_done) frames_seen++;
				if (pending_results.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					want = pending_results.pop_front();
					check_field("mask_bit", 24'(want.mask_bit), 24'(mask_bit));
					check_field("frame_done", 24'(want.frame_done), 24'(frame_done));
					check_field("centroid_x", 24'(want.centroid_x), 24'(centroid_x));
					check_field("centroid_y", 24'(want.centroid_y), 24'(centroid_y));
					check_field("match_count", 24'(want.match_count), 24'(match_count));
				end
			end
		end
	end

	always @(negedge clk) pop <= ($urandom_range(0, 99) >= recv_stall);

	// push stays high across back-to-back beats
	task automatic send_pixel(pixel_t px, logic typed, result_t want);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		cur_typed = typed;
		cur_want = want;
		push <= 1'b1;
		hue <= px.hue;
		saturation <= px.saturation;
		brightness <= px.brightness;
		end_of_line <= px.end_of_line;
		end_of_frame <= px.end_of_frame;
		do @(posedge clk); while (full);
		pixels_sent++;
	endtask

	task automatic end_burst();
		@(negedge clk);
		push <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
	endtask

	task automatic set_limits(logic [7:0] hl, logic [7:0] hh, logic [7:0] sl,
		logic [7:0] sh, logic [7:0] vl, logic [7:0] vh);
		write_reg(REG_SPARE_LO, 8'($urandom_range(0, 255)));
		write_reg(hsvtmc_pkg::REG_HUE_LOW, hl);
		write_reg(hsvtmc_pkg::REG_HUE_HIGH, hh);
		write_reg(hsvtmc_pkg::REG_SAT_LOW, sl);
		write_reg(hsvtmc_pkg::REG_SAT_HIGH, sh);
		write_reg(hsvtmc_pkg::REG_VAL_LOW, vl);
		write_reg(hsvtmc_pkg::REG_VAL_HIGH, vh);
		write_reg(REG_SPARE_HI, 8'($urandom_range(0, 255)));
		@(negedge clk);
		wr_en <= 1'b0;
		settings_used++;
	endtask

	// biased towards the limits and the accepted band
	function automatic logic [7:0] pick_channel(logic [7:0] lo, logic [7:0] hi);
		logic [7:0] span;
		span = hi - lo;
		case ($urandom_range(0, 9))
			0: return lo;
			1: return hi;
			2: return lo - 8'd1;
			3: return hi + 8'd1;
			4, 5: return 8'($urandom_range(0, 255));
			default: return lo + 8'($urandom_range(0, span));
		endcase
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t px;
		px.hue = pick_channel(limits[hsvtmc_pkg::REG_HUE_LOW],
			limits[hsvtmc_pkg::REG_HUE_HIGH]);
		px.saturation = pick_channel(limits[hsvtmc_pkg::REG_SAT_LOW],
			limits[hsvtmc_pkg::REG_SAT_HIGH]);
		px.brightness = pick_channel(limits[hsvtmc_pkg::REG_VAL_LOW],
			limits[hsvtmc_pkg::REG_VAL_HIGH]);
		px.end_of_line = ($urandom_range(0, 7) == 0);
		px.end_of_frame = ($urandom_range(0, 7) == 0);
		return px;
	endfunction

	task automatic send_frame(int width, int height);
		pixel_t px;
		for (int r = 0; r < height; r++) begin
			for (int c = 0; c < width; c++) begin
				px = random_pixel();
				px.end_of_frame = (r == height - 1) && (c == width - 1);
				px.end_of_line = (c == width - 1) && (!px.end_of_frame || $urandom_range(0, 1));
				send_pixel(px, 1'b0, R_NONE);
			end
		end
	endtask

	task automatic send_noise(int count);
		for (int i = 0; i < count; i++) send_pixel(random_pixel(), 1'b0, R_NONE);
	endtask

	initial begin : stimulus
		int target;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < $size(DIRECTED); i++) begin
			send_pixel(DIRECTED[i].px, DIRECTED[i].typed, DIRECTED[i].want);
		end
		end_burst();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: set_limits(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
				1: set_limits(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
				2: set_limits(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
				3: set_limits(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0);
				4: set_limits(8'd200, 8'd20, 8'd50, 8'd200, 8'd0, 8'd255);
				5: set_limits(8'd1, 8'd0, 8'd128, 8'd127, 8'd30, 8'd220);
				default: set_limits(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			endcase
			case (p % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 76; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 76; end
				default: begin send_idle = 31; recv_stall = 31; end
			endcase
			target = pixels_sent + PHASE_ITEMS;
			while (pixels_sent < target) begin
				if ($urandom_range(0, 9) < 8) begin
					send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
						: $urandom_range(1, 8), $urandom_range(1, 6));
				end else begin
					send_noise($urandom_range(1, 12));
				end
			end
			end_burst();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected result beats never arrived", pending_results.size());
			errors++;
		end
		$display("Checked %0d result beats from %0d pixels, %0d frames, %0d limit settings,",
			results_seen, pixels_sent, frames_seen, settings_used);
		$display("with idle and stall phases, wrapped and degenerate limits and full drains.");
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin : watchdog
		#1000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

/* sim.f */
rtl/hsvtmc_pkg.sv
rtl/hsvtmc_queue.sv
rtl/hsvtmc_front.sv
rtl/hsvtmc_back.sv
rtl/hsv_threshold_mask_centroid.sv
verif/testbench.sv
